/* rtl/xxh_pkg.sv */
// Shared constants, command and status types, and helper functions for the XXH32 hash block.
package xxh_pkg;

    // Standard XXH32 primes.
    localparam logic [31:0] PRIME1 = 32'h9E37_79B1;
    localparam logic [31:0] PRIME2 = 32'h85EB_CA77;
    localparam logic [31:0] PRIME3 = 32'hC2B2_AE3D;
    localparam logic [31:0] PRIME4 = 32'h27D4_EB2F;
    localparam logic [31:0] PRIME5 = 32'h1656_67B1;

    // Lane 0 starts at seed + PRIME1 + PRIME2, taken modulo 2^32.
    localparam logic [31:0] LANE0_OFS = PRIME1 + PRIME2;

    // Byte count of a complete word.
    localparam logic [2:0] WORD_BYTES = 3'd4;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE     = 4'd0,
        OP_LOAD     = 4'd1,
        OP_MUL_LANE = 4'd2,
        OP_MUL_WORD = 4'd3,
        OP_MUL_BYTE = 4'd4,
        OP_RND_LANE = 4'd5,
        OP_RND_WORD = 4'd6,
        OP_RND_BYTE = 4'd7,
        OP_H_START  = 4'd8,
        OP_ADD_L2   = 4'd9,
        OP_ADD_L3   = 4'd10,
        OP_ADD_LEN  = 4'd11,
        OP_AVAL1    = 4'd12,
        OP_AVAL2    = 4'd13,
        OP_EMIT     = 4'd14,
        OP_SPARE    = 4'd15
    } op_t;

    // Command from the controller: an operation and the lane, word or byte it acts on.
    typedef struct packed {
        op_t        op;
        logic [1:0] idx;
    } cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic       seen;
        logic [1:0] wcount;
        logic [2:0] tail_cnt;
        logic       out_busy;
    } status_t;

    // Rotate left by r bit positions.
    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] r);
        return (x << r) | (x >> (6'd32 - {1'b0, r}));
    endfunction

    // A beat carries a whole word unless it is the last one with fewer than four bytes.
    function automatic logic whole_word(input logic last, input logic [2:0] count);
        return !last || (count >= WORD_BYTES);
    endfunction

endpackage

/* rtl/xxh32_stream_hash.sv */
// Top level of the streaming XXH32 hash block.
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_valid / s_ready  s_data_word, s_byte_count, s_last
//   m_        out        m_valid / m_ready  m_hash_value
//   cfg_      in         cfg_wr_en          cfg_wr_data (hash seed)
//
// A beat that neither completes a stripe nor is last leaves the input open for the next beat.
// The beat that completes a stripe is followed by four lane rounds, each a multiply and a
// round step on the one shared 32x32 multiplier. A last beat then starts the hash, folds
// each leftover word and byte with a multiply and a round step, and ends with the avalanche
// and hand-over. Reset is synchronous and active low; it clears the seed, the message
// counters and flags and the output valid flag. A finished hash waits in the output register
// while the next message streams in; only the hand-over of the following hash waits for m_ready.
module xxh32_stream_hash (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_data_word,
    input  logic [2:0]  s_byte_count,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_hash_value
);

    xxh_pkg::cmd_t    cmd;
    xxh_pkg::status_t status;

    xxh_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_last       (s_last),
        .s_byte_count (s_byte_count),
        .s_ready      (s_ready),
        .status       (status),
        .cmd          (cmd)
    );

    xxh_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_data_word  (s_data_word),
        .s_byte_count (s_byte_count),
        .s_last       (s_last),
        .cmd          (cmd),
        .status       (status),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_hash_value (m_hash_value)
    );

    // A hash is only written into a free output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == xxh_pkg::OP_EMIT) |-> !(m_valid && !m_ready))
        else $error("hash emitted over a result that has not been taken");

    // A result appears only after a hash was emitted.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.op == xxh_pkg::OP_EMIT))
        else $error("result beat without an emitted hash");

    // Emitting a hash leaves clean message state and an open input.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == xxh_pkg::OP_EMIT) |=>
            (status.wcount == 2'd0 && !status.seen && s_ready))
        else $error("message state not cleared after the hash");

endmodule

/* rtl/xxh_datapath.sv */
// Datapath of the XXH32 hash block: message state, the shared multiplier and the output register.
module xxh_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [31:0]       cfg_wr_data,
    input  logic [31:0]       s_data_word,
    input  logic [2:0]        s_byte_count,
    input  logic              s_last,
    input  xxh_pkg::cmd_t     cmd,
    output xxh_pkg::status_t  status,
    input  logic              m_ready,
    output logic              m_valid,
    output logic [31:0]       m_hash_value
);

    // Control state.
    logic [31:0] seed_reg, seed_next;
    logic [1:0]  wptr_reg, wptr_next;
    logic [31:0] total_reg, total_next;
    logic        seen_reg, seen_next;
    logic [2:0]  tail_cnt_reg, tail_cnt_next;
    logic        out_valid_reg, out_valid_next;

    // Payload state.
    logic [31:0] stripe_reg [4];
    logic [31:0] stripe_next [4];
    logic [31:0] lane_reg [4];
    logic [31:0] lane_next [4];
    logic [31:0] tail_word_reg, tail_word_next;
    logic [31:0] prod_reg, prod_next;
    logic [31:0] h_reg, h_next;
    logic [31:0] hash_reg, hash_next;

    // Shared multiplier operands and result.
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [31:0] mul_res;
    logic [7:0]  tail_byte;

    assign tail_byte = tail_word_reg[{cmd.idx, 3'b000} +: 8];

    // Operand selection for the single multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            xxh_pkg::OP_MUL_LANE: begin
                mul_a = stripe_reg[cmd.idx];
                mul_b = xxh_pkg::PRIME2;
            end
            xxh_pkg::OP_MUL_WORD: begin
                mul_a = stripe_reg[cmd.idx];
                mul_b = xxh_pkg::PRIME3;
            end
            xxh_pkg::OP_MUL_BYTE: begin
                mul_a = {24'd0, tail_byte};
                mul_b = xxh_pkg::PRIME5;
            end
            xxh_pkg::OP_RND_LANE: begin
                mul_a = xxh_pkg::rotl32(lane_reg[cmd.idx] + prod_reg, 5'd13);
                mul_b = xxh_pkg::PRIME1;
            end
            xxh_pkg::OP_RND_WORD: begin
                mul_a = xxh_pkg::rotl32(h_reg + prod_reg, 5'd17);
                mul_b = xxh_pkg::PRIME4;
            end
            xxh_pkg::OP_RND_BYTE: begin
                mul_a = xxh_pkg::rotl32(h_reg + prod_reg, 5'd11);
                mul_b = xxh_pkg::PRIME1;
            end
            xxh_pkg::OP_AVAL1: begin
                mul_a = h_reg ^ (h_reg >> 15);
                mul_b = xxh_pkg::PRIME2;
            end
            xxh_pkg::OP_AVAL2: begin
                mul_a = h_reg ^ (h_reg >> 13);
                mul_b = xxh_pkg::PRIME3;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_res = mul_a * mul_b;

    // Next-state logic for every register.
    always_comb begin
        seed_next      = seed_reg;
        wptr_next      = wptr_reg;
        total_next     = total_reg;
        seen_next      = seen_reg;
        tail_cnt_next  = tail_cnt_reg;
        out_valid_next = out_valid_reg;
        stripe_next    = stripe_reg;
        lane_next      = lane_reg;
        tail_word_next = tail_word_reg;
        prod_next      = prod_reg;
        h_next         = h_reg;
        hash_next      = hash_reg;

        if (cfg_wr_en) begin
            seed_next = cfg_wr_data;
        end
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        case (cmd.op)
            xxh_pkg::OP_LOAD: begin
                if (xxh_pkg::whole_word(s_last, s_byte_count)) begin
                    stripe_next[wptr_reg] = s_data_word;
                    wptr_next             = wptr_reg + 2'd1;
                    total_next            = total_reg + 32'd4;
                    tail_cnt_next         = 3'd0;
                    // The first complete stripe seeds the lanes.
                    if (wptr_reg == 2'd3 && !seen_reg) begin
                        lane_next[0] = seed_reg + xxh_pkg::LANE0_OFS;
                        lane_next[1] = seed_reg + xxh_pkg::PRIME2;
                        lane_next[2] = seed_reg;
                        lane_next[3] = seed_reg - xxh_pkg::PRIME1;
                        seen_next    = 1'b1;
                    end
                end else begin
                    total_next     = total_reg + 32'(s_byte_count);
                    tail_cnt_next  = s_byte_count;
                    tail_word_next = s_data_word;
                end
            end
            xxh_pkg::OP_MUL_LANE, xxh_pkg::OP_MUL_WORD, xxh_pkg::OP_MUL_BYTE: begin
                prod_next = mul_res;
            end
            xxh_pkg::OP_RND_LANE: begin
                lane_next[cmd.idx] = mul_res;
            end
            xxh_pkg::OP_RND_WORD, xxh_pkg::OP_RND_BYTE,
            xxh_pkg::OP_AVAL1, xxh_pkg::OP_AVAL2: begin
                h_next = mul_res;
            end
            xxh_pkg::OP_H_START: begin
                if (seen_reg) begin
                    h_next = xxh_pkg::rotl32(lane_reg[0], 5'd1)
                           + xxh_pkg::rotl32(lane_reg[1], 5'd7);
                end else begin
                    h_next = seed_reg + xxh_pkg::PRIME5;
                end
            end
            xxh_pkg::OP_ADD_L2: begin
                h_next = h_reg + xxh_pkg::rotl32(lane_reg[2], 5'd12);
            end
            xxh_pkg::OP_ADD_L3: begin
                h_next = h_reg + xxh_pkg::rotl32(lane_reg[3], 5'd18);
            end
            xxh_pkg::OP_ADD_LEN: begin
                h_next = h_reg + total_reg;
            end
            xxh_pkg::OP_EMIT: begin
                // Final avalanche step, then the message state returns to its start.
                hash_next      = h_reg ^ (h_reg >> 16);
                out_valid_next = 1'b1;
                wptr_next      = 2'd0;
                total_next     = '0;
                seen_next      = 1'b0;
                tail_cnt_next  = 3'd0;
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg      <= '0;
            wptr_reg      <= 2'd0;
            total_reg     <= '0;
            seen_reg      <= 1'b0;
            tail_cnt_reg  <= 3'd0;
            out_valid_reg <= 1'b0;
        end else begin
            seed_reg      <= seed_next;
            wptr_reg      <= wptr_next;
            total_reg     <= total_next;
            seen_reg      <= seen_next;
            tail_cnt_reg  <= tail_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        stripe_reg    <= stripe_next;
        lane_reg      <= lane_next;
        tail_word_reg <= tail_word_next;
        prod_reg      <= prod_next;
        h_reg         <= h_next;
        hash_reg      <= hash_next;
    end

    // Status back to the controller.
    assign status.seen     = seen_reg;
    assign status.wcount   = wptr_reg;
    assign status.tail_cnt = tail_cnt_reg;
    assign status.out_busy = out_valid_reg && !m_ready;

    assign m_valid      = out_valid_reg;
    assign m_hash_value = hash_reg;

endmodule

/* rtl/xxh_ctrl.sv */
// Controller of the XXH32 hash block: sequences stripe absorption and hash finishing.
module xxh_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_last,
    input  logic [2:0]        s_byte_count,
    output logic              s_ready,
    input  xxh_pkg::status_t  status,
    output xxh_pkg::cmd_t     cmd
);

    typedef enum logic [13:0] {
        ST_IDLE   = 14'b00_0000_0000_0001,
        ST_LMUL   = 14'b00_0000_0000_0010,
        ST_LRND   = 14'b00_0000_0000_0100,
        ST_HSTART = 14'b00_0000_0000_1000,
        ST_HADD2  = 14'b00_0000_0001_0000,
        ST_HADD3  = 14'b00_0000_0010_0000,
        ST_HLEN   = 14'b00_0000_0100_0000,
        ST_WMUL   = 14'b00_0000_1000_0000,
        ST_WRND   = 14'b00_0001_0000_0000,
        ST_BMUL   = 14'b00_0010_0000_0000,
        ST_BRND   = 14'b00_0100_0000_0000,
        ST_AV1    = 14'b00_1000_0000_0000,
        ST_AV2    = 14'b01_0000_0000_0000,
        ST_EMIT   = 14'b10_0000_0000_0000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] k_reg, k_next;
    logic       last_reg, last_next;

    assign s_ready = (state_reg == ST_IDLE);

    // State transitions and command generation.
    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        last_next  = last_reg;
        cmd.op     = xxh_pkg::OP_NONE;
        cmd.idx    = k_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.op    = xxh_pkg::OP_LOAD;
                    last_next = s_last;
                    k_next    = 2'd0;
                    if (xxh_pkg::whole_word(s_last, s_byte_count) && status.wcount == 2'd3) begin
                        state_next = ST_LMUL;
                    end else if (s_last) begin
                        state_next = ST_HSTART;
                    end
                end
            end
            // Four lane rounds, each a multiply then an add-rotate-multiply.
            ST_LMUL: begin
                cmd.op     = xxh_pkg::OP_MUL_LANE;
                state_next = ST_LRND;
            end
            ST_LRND: begin
                cmd.op = xxh_pkg::OP_RND_LANE;
                k_next = k_reg + 2'd1;
                if (k_reg == 2'd3) begin
                    state_next = last_reg ? ST_HSTART : ST_IDLE;
                end else begin
                    state_next = ST_LMUL;
                end
            end
            // Start value: lane merge or the short-message form.
            ST_HSTART: begin
                cmd.op     = xxh_pkg::OP_H_START;
                state_next = status.seen ? ST_HADD2 : ST_HLEN;
            end
            ST_HADD2: begin
                cmd.op     = xxh_pkg::OP_ADD_L2;
                state_next = ST_HADD3;
            end
            ST_HADD3: begin
                cmd.op     = xxh_pkg::OP_ADD_L3;
                state_next = ST_HLEN;
            end
            ST_HLEN: begin
                cmd.op = xxh_pkg::OP_ADD_LEN;
                k_next = 2'd0;
                if (status.wcount != 2'd0) begin
                    state_next = ST_WMUL;
                end else if (status.tail_cnt != 3'd0) begin
                    state_next = ST_BMUL;
                end else begin
                    state_next = ST_AV1;
                end
            end
            // Fold the leftover whole words.
            ST_WMUL: begin
                cmd.op     = xxh_pkg::OP_MUL_WORD;
                state_next = ST_WRND;
            end
            ST_WRND: begin
                cmd.op = xxh_pkg::OP_RND_WORD;
                if (k_reg == status.wcount - 2'd1) begin
                    k_next     = 2'd0;
                    state_next = (status.tail_cnt != 3'd0) ? ST_BMUL : ST_AV1;
                end else begin
                    k_next     = k_reg + 2'd1;
                    state_next = ST_WMUL;
                end
            end
            // Fold the leftover bytes of a short last beat.
            ST_BMUL: begin
                cmd.op     = xxh_pkg::OP_MUL_BYTE;
                state_next = ST_BRND;
            end
            ST_BRND: begin
                cmd.op = xxh_pkg::OP_RND_BYTE;
                if (k_reg == status.tail_cnt[1:0] - 2'd1) begin
                    k_next     = 2'd0;
                    state_next = ST_AV1;
                end else begin
                    k_next     = k_reg + 2'd1;
                    state_next = ST_BMUL;
                end
            end
            ST_AV1: begin
                cmd.op     = xxh_pkg::OP_AVAL1;
                state_next = ST_AV2;
            end
            ST_AV2: begin
                cmd.op     = xxh_pkg::OP_AVAL2;
                state_next = ST_EMIT;
            end
            // Hand the hash over once the output register is free.
            ST_EMIT: begin
                if (!status.out_busy) begin
                    cmd.op     = xxh_pkg::OP_EMIT;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            k_reg     <= 2'd0;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            last_reg  <= last_next;
        end
    end

endmodule
